FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define MSE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define MSE_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `MSE_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

FILE: rtl/core/mse_pkg.sv
`timescale 1ns / 1ps
package mse_pkg;

  localparam int DATA_WORDS = 4096;
  localparam int CODE_WORDS = 4096;
  localparam int DATA_AW    = $clog2(DATA_WORDS);

  localparam int CFG_W       = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int PC_W        = 26;
  localparam int WORD_W      = 32;
  localparam int REG_AW      = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_WORD_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_WORD_COUNT = 2'd1;

  localparam logic [CFG_W-1:0] CODE_COUNT_RESET = 13'd4096;

  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_HALT    = 3'd1;
  localparam logic [2:0] STATUS_DIV0    = 3'd2;
  localparam logic [2:0] STATUS_UNKNOWN = 3'd3;
  localparam logic [2:0] STATUS_RANGE   = 3'd4;
  localparam logic [2:0] STATUS_GP      = 3'd5;
  localparam logic [2:0] STATUS_PCOUT   = 3'd6;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_MFHI = 6'd16;
  localparam logic [5:0] FN_MFLO = 6'd18;
  localparam logic [5:0] FN_MULT = 6'd24;
  localparam logic [5:0] FN_DIV  = 6'd26;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_SLT  = 6'd42;

  localparam logic [31:0] SYSCALL_WORD = 32'd12;
  localparam logic [31:0] SYS_PRINT    = 32'd1;
  localparam logic [31:0] SYS_READ     = 32'd5;
  localparam logic [31:0] SYS_EXIT     = 32'd10;

  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0   = 5'd4;
  localparam logic [REG_AW-1:0] REG_GP   = 5'd28;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_res_t;

endpackage

FILE: rtl/core/mse_ifs.sv
`timescale 1ns / 1ps
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] instr_word;
  logic [11:0] load_index;
  logic signed [31:0] data_value;

  modport source (output valid, mode, instr_word, load_index, data_value, input ready);
  modport sink (input valid, mode, instr_word, load_index, data_value, output ready);
endinterface

interface mse_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [25:0] next_pc;
  logic        print_valid;
  logic signed [31:0] print_value;
  logic        read_taken;

  modport source (output valid, status, next_pc, print_valid, print_value, read_taken,
                  input ready);
  modport sink (input valid, status, next_pc, print_valid, print_value, read_taken,
                output ready);
endinterface

FILE: rtl/core/mse_div.sv
`timescale 1ns / 1ps
module mse_div (
  input  logic              clk,
  input  logic              rst,
  input  mse_pkg::div_req_t div_req,
  output mse_pkg::div_res_t div_res
);

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] mag_b;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        busy  <= 1'b1;
        count <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      rem   <= '0;
      quo   <= div_req.dividend[31] ? -div_req.dividend : div_req.dividend;
      mag_b <= div_req.divisor[31] ? -div_req.divisor : div_req.divisor;
      neg_q <= div_req.dividend[31] ^ div_req.divisor[31];
      neg_r <= div_req.dividend[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign div_res.done      = done;
  assign div_res.quotient  = neg_q ? -quo : quo;
  assign div_res.remainder = neg_r ? -rem : rem;

endmodule

FILE: rtl/core/mips_subset_execute.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         mode, instr_word, load_index, data_value
// rsp      out        status, next_pc, print_valid, print_value, read_taken
// cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// A preload request writes data memory when it is taken; an instruction reads the register
// file and data memory when it is taken and executes and writes back in S_EXEC.
// A div then waits in S_DIV for the one-bit-per-cycle divider.
// Reset is synchronous and needs no clearing pass; data memory is undefined until written.
// A new request is taken only in idle and when the result register is free or being taken.
module mips_subset_execute (
  input  logic                                clk,
  input  logic                                rst,
  mse_in_if.sink                              req,
  mse_out_if.source                           rsp,
  input  logic                                cfg_we,
  input  logic [mse_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mse_pkg::CFG_W-1:0]           cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [12:0] code_words;
  logic [12:0] data_words;
  logic [31:0] gp_value;
  logic [25:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid;
  logic [31:0] rf_q_a;
  logic [31:0] rf_q_b;
  logic [31:0] dmem [mse_pkg::DATA_WORDS];
  logic [31:0] dmem_q;

  logic [31:0] instr;
  logic [31:0] dval;
  logic [4:0]  addr_a;
  logic [4:0]  addr_b;

  logic        out_valid;
  logic        out_valid_next;
  logic [2:0]  out_status;
  logic [25:0] out_npc;
  logic        out_pvalid;
  logic [31:0] out_pval;
  logic        out_rtaken;
  logic [2:0]  hold_status;
  logic [25:0] hold_npc;

  logic        accept;
  logic        syscall_in;
  logic [4:0]  raddr_a;
  logic [4:0]  raddr_b;

  logic [5:0]  op;
  logic [5:0]  funct;
  logic [15:0] imm;
  logic [31:0] a;
  logic [31:0] b;
  logic [2:0]  st;
  logic        fault;
  logic [25:0] npc;
  logic        wr_en;
  logic [4:0]  wr_addr;
  logic [31:0] wr_data;
  logic        pvalid;
  logic [31:0] pval;
  logic        rtaken;
  logic        mul_en;
  logic        sw_en;
  logic        range_bad;
  logic [31:0] gp_after;
  logic [15:0] cw16;
  logic [15:0] limit;
  logic signed [63:0] prod;

  mse_pkg::div_req_t div_req;
  mse_pkg::div_res_t div_res;

  mse_div u_div (
    .clk     (clk),
    .rst     (rst),
    .div_req (div_req),
    .div_res (div_res)
  );

  assign req.ready  = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign syscall_in = (req.instr_word == mse_pkg::SYSCALL_WORD);
  assign raddr_a    = syscall_in ? mse_pkg::REG_V0 : req.instr_word[25:21];
  assign raddr_b    = syscall_in ? mse_pkg::REG_A0 : req.instr_word[20:16];

  assign op    = instr[31:26];
  assign funct = instr[5:0];
  assign imm   = instr[15:0];

  always_comb begin
    if (addr_a == mse_pkg::REG_ZERO) begin
      a = '0;
    end else if (addr_a == mse_pkg::REG_GP) begin
      a = gp_value;
    end else begin
      a = rf_valid[addr_a] ? rf_q_a : '0;
    end
    if (addr_b == mse_pkg::REG_ZERO) begin
      b = '0;
    end else if (addr_b == mse_pkg::REG_GP) begin
      b = gp_value;
    end else begin
      b = rf_valid[addr_b] ? rf_q_b : '0;
    end
  end

  assign prod      = $signed(a) * $signed(b);
  assign range_bad = imm[15] || (17'(imm) >= 17'(data_words))
                     || (17'(imm) >= 17'(mse_pkg::DATA_WORDS));
  assign cw16      = 16'(code_words);
  assign limit     = (cw16 < 16'(mse_pkg::CODE_WORDS)) ? cw16 : 16'(mse_pkg::CODE_WORDS);

  always_comb begin
    st            = mse_pkg::STATUS_OK;
    fault         = 1'b0;
    npc           = pc + 26'd1;
    wr_en         = 1'b0;
    wr_addr       = instr[15:11];
    wr_data       = '0;
    pvalid        = 1'b0;
    pval          = '0;
    rtaken        = 1'b0;
    mul_en        = 1'b0;
    sw_en         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = a;
    div_req.divisor  = b;
    unique case (op)
      mse_pkg::OP_SPECIAL: begin
        if (instr == mse_pkg::SYSCALL_WORD) begin
          if (a == mse_pkg::SYS_PRINT) begin
            pvalid = 1'b1;
            pval   = (b[31:15] == 17'd1) ? (b | 32'hFFFF_0000) : b;
          end else if (a == mse_pkg::SYS_READ) begin
            wr_en   = 1'b1;
            wr_addr = mse_pkg::REG_V0;
            wr_data = dval;
            rtaken  = 1'b1;
          end else if (a == mse_pkg::SYS_EXIT) begin
            st    = mse_pkg::STATUS_HALT;
            fault = 1'b1;
          end
        end else begin
          unique case (funct)
            mse_pkg::FN_ADDU: begin wr_en = 1'b1; wr_data = a + b; end
            mse_pkg::FN_SUBU: begin wr_en = 1'b1; wr_data = a - b; end
            mse_pkg::FN_AND:  begin wr_en = 1'b1; wr_data = a & b; end
            mse_pkg::FN_OR:   begin wr_en = 1'b1; wr_data = a | b; end
            mse_pkg::FN_SLT:  begin
              wr_en   = 1'b1;
              wr_data = {31'd0, $signed(a) < $signed(b)};
            end
            mse_pkg::FN_MFHI: begin wr_en = 1'b1; wr_data = hi; end
            mse_pkg::FN_MFLO: begin wr_en = 1'b1; wr_data = lo; end
            mse_pkg::FN_MULT: mul_en = 1'b1;
            mse_pkg::FN_DIV: begin
              if (b == '0) begin
                st    = mse_pkg::STATUS_DIV0;
                fault = 1'b1;
              end else begin
                div_req.start = (state == S_EXEC);
              end
            end
            default: begin
              st    = mse_pkg::STATUS_UNKNOWN;
              fault = 1'b1;
            end
          endcase
        end
      end
      mse_pkg::OP_ADDIU: begin
        wr_en   = 1'b1;
        wr_addr = instr[20:16];
        wr_data = a + {{16{imm[15]}}, imm};
      end
      mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
        if ((op == mse_pkg::OP_BEQ) == (a == b)) begin
          npc = pc + {{10{imm[15]}}, imm};
        end
      end
      mse_pkg::OP_LW, mse_pkg::OP_SW: begin
        if (range_bad) begin
          st    = mse_pkg::STATUS_RANGE;
          fault = 1'b1;
        end else if (op == mse_pkg::OP_LW) begin
          wr_en   = 1'b1;
          wr_addr = instr[20:16];
          wr_data = dmem_q;
        end else begin
          sw_en = 1'b1;
        end
      end
      mse_pkg::OP_J: npc = instr[25:0];
      default: begin
        st    = mse_pkg::STATUS_UNKNOWN;
        fault = 1'b1;
      end
    endcase
    if (fault) begin
      npc = pc;
    end
    wr_en    = wr_en && (wr_addr != mse_pkg::REG_ZERO);
    gp_after = (wr_en && wr_addr == mse_pkg::REG_GP) ? wr_data : gp_value;
    if (!fault) begin
      if (gp_after != 32'(code_words)) begin
        st = mse_pkg::STATUS_GP;
      end else if (npc >= 26'(limit)) begin
        st = mse_pkg::STATUS_PCOUT;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && !req.mode) state_next = S_EXEC;
      S_EXEC: state_next = div_req.start ? S_DIV : S_IDLE;
      S_DIV:  if (div_res.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !rsp.ready;
    if ((accept && req.mode) || (state == S_EXEC && !div_req.start)
        || (state == S_DIV && div_res.done)) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rf_q_a <= rf_mem[raddr_a];
      rf_q_b <= rf_mem[raddr_b];
      dmem_q <= dmem[mse_pkg::DATA_AW'(req.instr_word[15:0])];
      instr  <= req.instr_word;
      dval   <= req.data_value;
      addr_a <= raddr_a;
      addr_b <= raddr_b;
      if (req.mode && (32'(req.load_index) < 32'(mse_pkg::DATA_WORDS))) begin
        dmem[mse_pkg::DATA_AW'(req.load_index)] <= req.data_value;
      end
    end
    if (state == S_EXEC) begin
      if (wr_en) begin
        rf_mem[wr_addr] <= wr_data;
      end
      if (sw_en) begin
        dmem[mse_pkg::DATA_AW'(imm)] <= b;
      end
      hold_status <= st;
      hold_npc    <= npc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      code_words <= mse_pkg::CODE_COUNT_RESET;
      data_words <= '0;
      gp_value   <= 32'(mse_pkg::CODE_COUNT_RESET);
      pc         <= '0;
      hi         <= '0;
      lo         <= '0;
      rf_valid   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_we && cfg_index == mse_pkg::CFG_CODE_WORD_COUNT) begin
        code_words <= cfg_data;
        gp_value   <= 32'(cfg_data);
      end else if (cfg_we && cfg_index == mse_pkg::CFG_DATA_WORD_COUNT) begin
        data_words <= cfg_data;
      end
      if (state == S_EXEC) begin
        if (wr_en) begin
          rf_valid[wr_addr] <= 1'b1;
          if (wr_addr == mse_pkg::REG_GP) begin
            gp_value <= wr_data;
          end
        end
        if (!fault) begin
          pc <= npc;
        end
        if (mul_en) begin
          lo <= prod[31:0];
          hi <= prod[63:32];
        end
      end
      if (state == S_DIV && div_res.done) begin
        lo <= div_res.quotient;
        hi <= div_res.remainder;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.mode) begin
      out_status <= mse_pkg::STATUS_OK;
      out_npc    <= pc;
      out_pvalid <= 1'b0;
      out_pval   <= '0;
      out_rtaken <= 1'b0;
    end else if (state == S_EXEC) begin
      out_status <= st;
      out_npc    <= npc;
      out_pvalid <= pvalid;
      out_pval   <= pval;
      out_rtaken <= rtaken;
    end else if (state == S_DIV && div_res.done) begin
      out_status <= hold_status;
      out_npc    <= hold_npc;
      out_pvalid <= 1'b0;
      out_pval   <= '0;
      out_rtaken <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.next_pc     = out_npc;
  assign rsp.print_valid = out_pvalid;
  assign rsp.print_value = out_pval;
  assign rsp.read_taken  = out_rtaken;

endmodule

FILE: rtl/core/mse_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mse_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_mode,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic        rsp_print_valid,
  input logic [31:0] rsp_print_value,
  input logic        rsp_read_taken
);

  `MSE_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")
  `MSE_ASSERT_NEVER(a_accept_blocked, clk, rst, req_valid && req_ready && rsp_valid && !rsp_ready, "request taken while result stalled")
  `MSE_ASSERT(a_preload_result, clk, rst, req_valid && req_ready && req_mode |=> rsp_valid && rsp_status == mse_pkg::STATUS_OK && !rsp_print_valid && !rsp_read_taken, "bad preload result")
  `MSE_ASSERT(a_print_zero, clk, rst, rsp_valid && !rsp_print_valid |-> rsp_print_value == 32'd0, "print value without print")
  `MSE_ASSERT_NEVER(a_one_kind, clk, rst, rsp_valid && rsp_print_valid && rsp_read_taken, "print and read in one result")

endmodule

bind mips_subset_execute mse_checker u_mse_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_mode        (req.mode),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_print_valid (rsp.print_valid),
  .rsp_print_value (rsp.print_value),
  .rsp_read_taken  (rsp.read_taken)
);
